### rtl/ufrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufrb_pkg
// Shared types and constants for the UART FIFO register block.
// ----------------------------------------------------------------------------
package ufrb_pkg;

    localparam int DEFAULT_FIFO_DEPTH = 16;

    // Event kinds on the command port
    typedef enum logic [1:0] {
        MODE_BUS_READ  = 2'd0,
        MODE_BUS_WRITE = 2'd1,
        MODE_LINE_RX   = 2'd2,
        MODE_TX_TAKE   = 2'd3
    } mode_t;

    // Register words
    localparam logic [1:0] REG_RX_DATA = 2'd0;
    localparam logic [1:0] REG_TX_DATA = 2'd1;
    localparam logic [1:0] REG_STATUS  = 2'd2;
    localparam logic [1:0] REG_CONTROL = 2'd3;

    // Status bit positions
    localparam int ST_PARITY   = 7;
    localparam int ST_FRAMING  = 6;
    localparam int ST_OVERRUN  = 5;
    localparam int ST_IRQ_EN   = 4;
    localparam int ST_TX_FULL  = 3;
    localparam int ST_TX_EMPTY = 2;
    localparam int ST_RX_FULL  = 1;
    localparam int ST_RX_VALID = 0;

    // Control bit positions
    localparam int CT_TX_RESET = 0;
    localparam int CT_RX_RESET = 1;
    localparam int CT_IRQ_EN   = 4;

    // Sticky error flag positions
    localparam int ERR_PARITY  = 2;
    localparam int ERR_FRAMING = 1;
    localparam int ERR_OVERRUN = 0;

    // Result control handed from the controller to the output mux
    typedef struct packed {
        logic       done;
        logic       rx_pop;
        logic       tx_pop;
        logic [7:0] reg_data;
        logic       irq;
    } rsp_t;

endpackage
`default_nettype wire

### rtl/ufrb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufrb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ufrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/ufrb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufrb_ctrl
// FIFO pointers, fill counts, flags; drives the FIFO RAM ports per event.
// ----------------------------------------------------------------------------
module ufrb_ctrl
    import ufrb_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
    localparam int FW = $clog2(FIFO_DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [1:0]    mode,
    input  wire logic [1:0]    reg_index,
    input  wire logic [7:0]    write_data,
    input  wire logic          rx_parity_error,
    input  wire logic          rx_framing_error,
    // TX FIFO RAM
    output logic               tx_we,
    output logic [AW-1:0]      tx_waddr,
    output logic               tx_re,
    output logic [AW-1:0]      tx_raddr,
    // RX FIFO RAM
    output logic               rx_we,
    output logic [AW-1:0]      rx_waddr,
    output logic               rx_re,
    output logic [AW-1:0]      rx_raddr,
    output rsp_t               rsp
);

    localparam int SW = AW + 1;

    logic [AW-1:0] tx_head_reg, tx_head_next;
    logic [FW-1:0] tx_fill_reg, tx_fill_next;
    logic [AW-1:0] rx_head_reg, rx_head_next;
    logic [FW-1:0] rx_fill_reg, rx_fill_next;
    logic          irq_en_reg, irq_en_next;
    logic [2:0]    err_reg, err_next;
    rsp_t          rsp_reg, rsp_next;

    logic          tx_full, tx_empty, rx_full, rx_empty;
    logic [7:0]    status;
    logic [SW-1:0] tx_sum, rx_sum;
    logic [AW-1:0] tx_tail, rx_tail;
    mode_t         mode_e;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign mode_e   = mode_t'(mode);
    assign tx_full  = (tx_fill_reg == FW'(FIFO_DEPTH));
    assign tx_empty = (tx_fill_reg == '0);
    assign rx_full  = (rx_fill_reg == FW'(FIFO_DEPTH));
    assign rx_empty = (rx_fill_reg == '0);

    // tail = (head + fill) mod depth; sum stays below twice the depth
    assign tx_sum  = SW'(tx_head_reg) + SW'(tx_fill_reg);
    assign rx_sum  = SW'(rx_head_reg) + SW'(rx_fill_reg);
    assign tx_tail = (tx_sum >= SW'(FIFO_DEPTH)) ? AW'(tx_sum - SW'(FIFO_DEPTH))
                                                 : AW'(tx_sum);
    assign rx_tail = (rx_sum >= SW'(FIFO_DEPTH)) ? AW'(rx_sum - SW'(FIFO_DEPTH))
                                                 : AW'(rx_sum);

    always_comb
    begin
        status              = '0;
        status[ST_PARITY]   = err_reg[ERR_PARITY];
        status[ST_FRAMING]  = err_reg[ERR_FRAMING];
        status[ST_OVERRUN]  = err_reg[ERR_OVERRUN];
        status[ST_IRQ_EN]   = irq_en_reg;
        status[ST_TX_FULL]  = tx_full;
        status[ST_TX_EMPTY] = tx_empty;
        status[ST_RX_FULL]  = rx_full;
        status[ST_RX_VALID] = !rx_empty;
    end

    always_comb
    begin
        tx_head_next = tx_head_reg;
        tx_fill_next = tx_fill_reg;
        rx_head_next = rx_head_reg;
        rx_fill_next = rx_fill_reg;
        irq_en_next  = irq_en_reg;
        err_next     = err_reg;
        tx_we        = 1'b0;
        tx_waddr     = tx_tail;
        tx_re        = 1'b0;
        tx_raddr     = tx_head_reg;
        rx_we        = 1'b0;
        rx_waddr     = rx_tail;
        rx_re        = 1'b0;
        rx_raddr     = rx_head_reg;
        rsp_next     = '0;

        if (accept)
        begin
            rsp_next.done = 1'b1;
            case (mode_e)
                MODE_BUS_READ:
                begin
                    if (reg_index == REG_RX_DATA && !rx_empty)
                    begin
                        rx_re           = 1'b1;
                        rsp_next.rx_pop = 1'b1;
                        rx_head_next    = ptr_inc(rx_head_reg);
                        rx_fill_next    = rx_fill_reg - FW'(1);
                    end
                    else if (reg_index == REG_STATUS)
                    begin
                        rsp_next.reg_data = status;
                        err_next          = '0;
                    end
                end
                MODE_BUS_WRITE:
                begin
                    if (reg_index == REG_TX_DATA && !tx_full)
                    begin
                        tx_we        = 1'b1;
                        tx_fill_next = tx_fill_reg + FW'(1);
                    end
                    else if (reg_index == REG_CONTROL)
                    begin
                        if (write_data[CT_TX_RESET])
                        begin
                            tx_head_next = '0;
                            tx_fill_next = '0;
                        end
                        if (write_data[CT_RX_RESET])
                        begin
                            rx_head_next = '0;
                            rx_fill_next = '0;
                        end
                        irq_en_next = write_data[CT_IRQ_EN];
                    end
                end
                MODE_LINE_RX:
                begin
                    err_next[ERR_PARITY]  = err_reg[ERR_PARITY] | rx_parity_error;
                    err_next[ERR_FRAMING] = err_reg[ERR_FRAMING] | rx_framing_error;
                    if (rx_full)
                    begin
                        err_next[ERR_OVERRUN] = 1'b1;
                    end
                    else
                    begin
                        rx_we        = 1'b1;
                        rx_fill_next = rx_fill_reg + FW'(1);
                    end
                end
                MODE_TX_TAKE:
                begin
                    if (!tx_empty)
                    begin
                        tx_re           = 1'b1;
                        rsp_next.tx_pop = 1'b1;
                        tx_head_next    = ptr_inc(tx_head_reg);
                        tx_fill_next    = tx_fill_reg - FW'(1);
                    end
                end
                default:
                begin
                end
            endcase
            rsp_next.irq = irq_en_next && (rx_fill_next != '0 || tx_fill_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg <= '0;
            tx_fill_reg <= '0;
            rx_head_reg <= '0;
            rx_fill_reg <= '0;
            irq_en_reg  <= 1'b0;
            err_reg     <= '0;
            rsp_reg     <= '0;
        end
        else
        begin
            tx_head_reg <= tx_head_next;
            tx_fill_reg <= tx_fill_next;
            rx_head_reg <= rx_head_next;
            rx_fill_reg <= rx_fill_next;
            irq_en_reg  <= irq_en_next;
            err_reg     <= err_next;
            rsp_reg     <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire

### rtl/uart_fifo_register_block_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_fifo_register_block_core
// Register side of a lite UART: TX and RX FIFOs, status, control, interrupt.
// ----------------------------------------------------------------------------
// Usage:
//   Command port: drive mode/reg_index/write_data/rx_byte and the two rx
//   error bits, raise start. A word is taken on each clock edge where
//   start is high and busy is low. busy never rises: every event is one
//   FIFO push, one FIFO pop or one register access, so a new word may be
//   issued every cycle (one word per cycle sustained).
//   Result port: done pulses in the cycle after the word is taken,
//   with read_data, tx_byte, tx_valid and irq valid in that same cycle.
//   The receiver cannot stall; results must be sampled on the strobe.
//   Popped bytes come from the registered read of the FIFO RAMs.
//   A pop reads the RAM at the head; a push writes the RAM at the tail.
//   The pointers live in flops, so a push followed next cycle by a pop
//   of the same entry reads the freshly written data from the RAM.
//   Reset (rst_n low, async) clears pointers, fill counts, the interrupt
//   enable and the sticky error flags. The FIFO RAMs are not cleared; only
//   occupied entries are ever read.
// ----------------------------------------------------------------------------
module uart_fifo_register_block_core
    import ufrb_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Command port
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] mode,
    input  wire logic [1:0] reg_index,
    input  wire logic [7:0] write_data,
    input  wire logic [7:0] rx_byte,
    input  wire logic       rx_parity_error,
    input  wire logic       rx_framing_error,
    // Result port
    output logic            done,
    output logic [7:0]      read_data,
    output logic [7:0]      tx_byte,
    output logic            tx_valid,
    output logic            irq
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic          accept;
    logic          tx_we, tx_re, rx_we, rx_re;
    logic [AW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
    logic [7:0]    tx_rdata, rx_rdata;
    rsp_t          rsp;

    // Every event is one push, pop or register access, nothing to hold off
    assign busy   = 1'b0;
    assign accept = start && !busy;

    ufrb_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .mode             (mode),
        .reg_index        (reg_index),
        .write_data       (write_data),
        .rx_parity_error  (rx_parity_error),
        .rx_framing_error (rx_framing_error),
        .tx_we            (tx_we),
        .tx_waddr         (tx_waddr),
        .tx_re            (tx_re),
        .tx_raddr         (tx_raddr),
        .rx_we            (rx_we),
        .rx_waddr         (rx_waddr),
        .rx_re            (rx_re),
        .rx_raddr         (rx_raddr),
        .rsp              (rsp)
    );

    // TX FIFO storage: written by bus, read by transmitter
    ufrb_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (write_data),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // RX FIFO storage: written by line receiver, read by bus
    ufrb_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_byte),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    // Output mux: popped bytes come straight from the RAM read registers
    assign done      = rsp.done;
    assign read_data = rsp.rx_pop ? rx_rdata : rsp.reg_data;
    assign tx_byte   = rsp.tx_pop ? tx_rdata : 8'h00;
    assign tx_valid  = rsp.tx_pop;
    assign irq       = rsp.irq;

endmodule
`default_nettype wire

### tb/tb_uart_fifo_register_block_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_uart_fifo_register_block_core
// Self-checking bench for the UART FIFO register block: bus reads and writes,
// line arrivals and transmitter takes go in on the command port. Every word
// is predicted by a shadow copy of the FIFOs, flags and interrupt enable. The
// one-cycle result strobe is checked field by field against that prediction.
// ----------------------------------------------------------------------------
module tb_uart_fifo_register_block_core;
    import ufrb_pkg::*;

    localparam int DEPTH       = DEFAULT_FIFO_DEPTH;
    localparam int CYCLE_LIMIT = 500000;  // far above the slowest legal run

    // Traffic shape for the random part: keep the FIFOs moving between
    // empty and full so both boundaries are hit often.
    typedef enum int {
        TREND_BALANCED,
        TREND_FILL,
        TREND_DRAIN
    } trend_t;

    // One expected result word
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       irq;
    } uart_resp_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    mode_t      mode;
    logic [1:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
    logic       rx_parity_error;
    logic       rx_framing_error;
    logic       done;
    logic [7:0] read_data;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       irq;

    // Shadow state of the block
    logic [7:0] shadow_tx_fifo [DEPTH];
    logic [7:0] shadow_rx_fifo [DEPTH];
    logic [3:0] shadow_tx_head;
    logic [4:0] shadow_tx_fill;
    logic [3:0] shadow_rx_head;
    logic [4:0] shadow_rx_fill;
    logic       shadow_irq_en;
    logic [2:0] shadow_err;

    uart_resp_t pending_resp[$];

    int err_count;
    int words_sent;
    int results_checked;
    int tx_drops;
    int rx_overruns;
    int irq_high_results;
    int cycle_count;

    uart_fifo_register_block_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .reg_index        (reg_index),
        .write_data       (write_data),
        .rx_byte          (rx_byte),
        .rx_parity_error  (rx_parity_error),
        .rx_framing_error (rx_framing_error),
        .done             (done),
        .read_data        (read_data),
        .tx_byte          (tx_byte),
        .tx_valid         (tx_valid),
        .irq              (irq)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_resp.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shadow model: applies one accepted word and returns its result.
    // Status is sampled before the error flags are cleared; the interrupt
    // is evaluated after the word has updated the FIFOs.
    // ------------------------------------------------------------------------
    function automatic uart_resp_t apply_uart_word(mode_t m, logic [1:0] r,
                                                   logic [7:0] wd, logic [7:0] rb,
                                                   logic pe, logic fe);
        uart_resp_t res;
        logic [7:0] st;
        logic [3:0] tail;
        res = '0;
        case (m)
            MODE_BUS_READ:
            begin
                if (r == REG_RX_DATA)
                begin
                    // empty RX read answers zero and leaves state alone
                    if (shadow_rx_fill != 0)
                    begin
                        res.read_data  = shadow_rx_fifo[shadow_rx_head];
                        shadow_rx_head = shadow_rx_head + 4'd1;
                        shadow_rx_fill = shadow_rx_fill - 5'd1;
                    end
                end
                else if (r == REG_STATUS)
                begin
                    st = '0;
                    st[ST_PARITY]   = shadow_err[ERR_PARITY];
                    st[ST_FRAMING]  = shadow_err[ERR_FRAMING];
                    st[ST_OVERRUN]  = shadow_err[ERR_OVERRUN];
                    st[ST_IRQ_EN]   = shadow_irq_en;
                    st[ST_TX_FULL]  = (shadow_tx_fill >= DEPTH);
                    st[ST_TX_EMPTY] = (shadow_tx_fill == 0);
                    st[ST_RX_FULL]  = (shadow_rx_fill >= DEPTH);
                    st[ST_RX_VALID] = (shadow_rx_fill != 0);
                    res.read_data   = st;
                    shadow_err      = '0;
                end
            end
            MODE_BUS_WRITE:
            begin
                if (r == REG_TX_DATA)
                begin
                    if (shadow_tx_fill < DEPTH)
                    begin
                        tail = shadow_tx_head + shadow_tx_fill[3:0];
                        shadow_tx_fifo[tail] = wd;
                        shadow_tx_fill = shadow_tx_fill + 5'd1;
                    end
                    else
                        tx_drops++;
                end
                else if (r == REG_CONTROL)
                begin
                    if (wd[CT_TX_RESET])
                    begin
                        shadow_tx_head = '0;
                        shadow_tx_fill = '0;
                    end
                    if (wd[CT_RX_RESET])
                    begin
                        shadow_rx_head = '0;
                        shadow_rx_fill = '0;
                    end
                    shadow_irq_en = wd[CT_IRQ_EN];
                end
            end
            MODE_LINE_RX:
            begin
                // line flags stick even when the byte itself is dropped
                if (pe)
                    shadow_err[ERR_PARITY] = 1'b1;
                if (fe)
                    shadow_err[ERR_FRAMING] = 1'b1;
                if (shadow_rx_fill >= DEPTH)
                begin
                    shadow_err[ERR_OVERRUN] = 1'b1;
                    rx_overruns++;
                end
                else
                begin
                    tail = shadow_rx_head + shadow_rx_fill[3:0];
                    shadow_rx_fifo[tail] = rb;
                    shadow_rx_fill = shadow_rx_fill + 5'd1;
                end
            end
            default:
            begin
                if (shadow_tx_fill != 0)
                begin
                    res.tx_byte    = shadow_tx_fifo[shadow_tx_head];
                    res.tx_valid   = 1'b1;
                    shadow_tx_head = shadow_tx_head + 4'd1;
                    shadow_tx_fill = shadow_tx_fill - 5'd1;
                end
            end
        endcase
        res.irq = shadow_irq_en && (shadow_rx_fill != 0 || shadow_tx_fill == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every strobe must match the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        uart_resp_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (pending_resp.size() == 0)
            begin
                $error("result strobe with no word outstanding");
                err_count++;
            end
            else
            begin
                exp_r = pending_resp.pop_front();
                results_checked++;
                if (exp_r.irq)
                    irq_high_results++;
                if (read_data !== exp_r.read_data)
                begin
                    $error("read_data: expected %02h, actual %02h",
                           exp_r.read_data, read_data);
                    err_count++;
                end
                if (tx_byte !== exp_r.tx_byte)
                begin
                    $error("tx_byte: expected %02h, actual %02h", exp_r.tx_byte, tx_byte);
                    err_count++;
                end
                if (tx_valid !== exp_r.tx_valid)
                begin
                    $error("tx_valid: expected %0b, actual %0b", exp_r.tx_valid, tx_valid);
                    err_count++;
                end
                if (irq !== exp_r.irq)
                begin
                    $error("irq: expected %0b, actual %0b", exp_r.irq, irq);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side helpers
    // ------------------------------------------------------------------------

    // Drive one word and hold it until taken. start stays high on return so
    // back-to-back words need no extra edge; idle_gap lowers it.
    task automatic send_word(input mode_t m, input logic [1:0] r, input logic [7:0] wd,
                             input logic [7:0] rb, input logic pe, input logic fe);
        @(negedge clk);
        start            <= 1'b1;
        mode             <= m;
        reg_index        <= r;
        write_data       <= wd;
        rx_byte          <= rb;
        rx_parity_error  <= pe;
        rx_framing_error <= fe;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_resp.push_back(apply_uart_word(m, r, wd, rb, pe, fe));
        words_sent++;
    endtask

    // Lower start and idle, with junk on the data inputs to show they are
    // ignored while start is low.
    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start            <= 1'b0;
            mode             <= mode_t'(2'($urandom_range(3)));
            reg_index        <= 2'($urandom_range(3));
            write_data       <= 8'($urandom_range(255));
            rx_byte          <= 8'($urandom_range(255));
            rx_parity_error  <= 1'($urandom_range(1));
            rx_framing_error <= 1'($urandom_range(1));
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    // Mostly none, often a few cycles, now and then a long pause.
    task automatic random_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            idle_gap(0);
        else if (pick < 92)
            idle_gap($urandom_range(1, 3));
        else
            idle_gap($urandom_range(8, 40));
    endtask

    // Stop sending until every predicted result has come back.
    task automatic wait_all_results();
        idle_gap(1);
        while (pending_resp.size() != 0)
            @(posedge clk);
    endtask

    // One random word, its kind weighted by the current trend. All data
    // fields are random on every word, even where the block ignores them.
    task automatic send_random_word(input trend_t trend);
        int pick;
        int c_txw, c_rxa, c_rxr, c_txt;
        logic [7:0] wd;
        logic [7:0] rb;
        logic [1:0] r;
        logic pe, fe;
        case (trend)
            TREND_FILL:  begin c_txw = 35; c_rxa = 70; c_rxr = 80; c_txt = 90; end
            TREND_DRAIN: begin c_txw = 10; c_rxa = 20; c_rxr = 55; c_txt = 90; end
            default:     begin c_txw = 22; c_rxa = 44; c_rxr = 66; c_txt = 88; end
        endcase
        pick = $urandom_range(99);
        wd   = 8'($urandom_range(255));
        rb   = 8'($urandom_range(255));
        r    = 2'($urandom_range(3));
        pe   = ($urandom_range(7) == 0);
        fe   = ($urandom_range(7) == 0);
        if (pick < c_txw)
            send_word(MODE_BUS_WRITE, REG_TX_DATA, wd, rb, pe, fe);
        else if (pick < c_rxa)
            send_word(MODE_LINE_RX, r, wd, rb, pe, fe);
        else if (pick < c_rxr)
            send_word(MODE_BUS_READ, REG_RX_DATA, wd, rb, pe, fe);
        else if (pick < c_txt)
            send_word(MODE_TX_TAKE, r, wd, rb, pe, fe);
        else if (pick < 95)
            send_word(MODE_BUS_READ, REG_STATUS, wd, rb, pe, fe);
        else if (pick < 97)
        begin
            // FIFO resets are kept rare so the FIFOs get a chance to fill
            if ($urandom_range(3) != 0)
            begin
                wd[CT_TX_RESET] = 1'b0;
                wd[CT_RX_RESET] = 1'b0;
            end
            send_word(MODE_BUS_WRITE, REG_CONTROL, wd, rb, pe, fe);
        end
        else if ($urandom_range(1) == 0)
            send_word(MODE_BUS_READ, $urandom_range(1) ? REG_TX_DATA : REG_CONTROL,
                      wd, rb, pe, fe);
        else
            send_word(MODE_BUS_WRITE, $urandom_range(1) ? REG_RX_DATA : REG_STATUS,
                      wd, rb, pe, fe);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset state, ignored accesses, empty reads and takes, sticky flags,
    // status clear, and control writes with every bit set and cleared.
    task automatic test_directed();
        send_word(MODE_BUS_READ,  REG_STATUS,  8'h00, 8'h00, 1'b0, 1'b0);
        send_word(MODE_BUS_READ,  REG_RX_DATA, 8'h00, 8'h00, 1'b0, 1'b0);
        send_word(MODE_TX_TAKE,   REG_RX_DATA, 8'h00, 8'h00, 1'b0, 1'b0);
        send_word(MODE_BUS_READ,  REG_TX_DATA, 8'hFF, 8'hFF, 1'b1, 1'b1);
        send_word(MODE_BUS_READ,  REG_CONTROL, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_word(MODE_BUS_WRITE, REG_RX_DATA, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_word(MODE_BUS_WRITE, REG_STATUS,  8'hFF, 8'h00, 1'b0, 1'b0);
        send_word(MODE_BUS_WRITE, REG_CONTROL, 8'h10, 8'h00, 1'b0, 1'b0);
        send_word(MODE_BUS_WRITE, REG_TX_DATA, 8'h00, 8'h00, 1'b0, 1'b0);
        idle_gap(2);
        send_word(MODE_BUS_WRITE, REG_TX_DATA, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_word(MODE_LINE_RX,   REG_RX_DATA, 8'h00, 8'hFF, 1'b1, 1'b0);
        send_word(MODE_LINE_RX,   REG_STATUS,  8'h00, 8'h00, 1'b0, 1'b1);
        send_word(MODE_LINE_RX,   REG_CONTROL, 8'h00, 8'hA5, 1'b1, 1'b1);
        send_word(MODE_BUS_READ,  REG_STATUS,  8'h00, 8'h00, 1'b0, 1'b0);
        send_word(MODE_BUS_READ,  REG_STATUS,  8'h00, 8'h00, 1'b0, 1'b0);
        send_word(MODE_TX_TAKE,   REG_TX_DATA, 8'h00, 8'h00, 1'b0, 1'b0);
        send_word(MODE_TX_TAKE,   REG_TX_DATA, 8'h00, 8'h00, 1'b0, 1'b0);
        send_word(MODE_TX_TAKE,   REG_TX_DATA, 8'h00, 8'h00, 1'b0, 1'b0);
        repeat (4)
            send_word(MODE_BUS_READ, REG_RX_DATA, 8'h00, 8'h00, 1'b0, 1'b0);
        // control with both FIFO resets while each holds a byte
        send_word(MODE_BUS_WRITE, REG_TX_DATA, 8'h5A, 8'h00, 1'b0, 1'b0);
        send_word(MODE_LINE_RX,   REG_RX_DATA, 8'h00, 8'h3C, 1'b0, 1'b0);
        send_word(MODE_BUS_WRITE, REG_CONTROL, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_word(MODE_BUS_READ,  REG_STATUS,  8'h00, 8'h00, 1'b0, 1'b0);
        send_word(MODE_BUS_WRITE, REG_CONTROL, 8'h00, 8'h00, 1'b0, 1'b0);
        wait_all_results();
    endtask

    // Both FIFOs pushed past full (TX drop, RX overrun), status showing the
    // full bits, then drained past empty. Pointers wrap on the way.
    task automatic test_fifo_limits();
        send_word(MODE_BUS_WRITE, REG_CONTROL, 8'h10, 8'h00, 1'b0, 1'b0);
        repeat (DEPTH + 2)
        begin
            send_word(MODE_BUS_WRITE, REG_TX_DATA, 8'($urandom_range(255)), 8'h00,
                      1'b0, 1'b0);
            random_gap();
        end
        repeat (DEPTH + 2)
        begin
            send_word(MODE_LINE_RX, REG_RX_DATA, 8'h00, 8'($urandom_range(255)),
                      1'b0, 1'b0);
            random_gap();
        end
        send_word(MODE_BUS_READ, REG_STATUS, 8'h00, 8'h00, 1'b0, 1'b0);
        repeat (DEPTH + 1)
        begin
            send_word(MODE_TX_TAKE, REG_TX_DATA, 8'h00, 8'h00, 1'b0, 1'b0);
            send_word(MODE_BUS_READ, REG_RX_DATA, 8'h00, 8'h00, 1'b0, 1'b0);
            random_gap();
        end
        send_word(MODE_BUS_READ, REG_STATUS, 8'h00, 8'h00, 1'b0, 1'b0);
        wait_all_results();
    endtask

    // Word every cycle: push then pop of the same entry on adjacent cycles.
    task automatic test_back_to_back();
        for (int i = 0; i < 300; i++)
            send_random_word((i / 25) % 2 == 0 ? TREND_FILL : TREND_DRAIN);
        wait_all_results();
    endtask

    // Long random traffic in trend blocks with random gaps; every few
    // hundred words the sender holds off until the block has gone quiet.
    task automatic test_random_traffic();
        int sent;
        int block_len;
        trend_t trend;
        sent = 0;
        while (sent < 1500)
        begin
            block_len = $urandom_range(20, 60);
            trend     = trend_t'($urandom_range(2));
            for (int i = 0; i < block_len; i++)
            begin
                send_random_word(trend);
                random_gap();
                sent++;
                if (sent % 300 == 0)
                    wait_all_results();
            end
        end
        wait_all_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        err_count        = 0;
        words_sent       = 0;
        results_checked  = 0;
        tx_drops         = 0;
        rx_overruns      = 0;
        irq_high_results = 0;
        cycle_count      = 0;
        shadow_tx_head   = '0;
        shadow_tx_fill   = '0;
        shadow_rx_head   = '0;
        shadow_rx_fill   = '0;
        shadow_irq_en    = 1'b0;
        shadow_err       = '0;
        rst_n            = 1'b0;
        start            = 1'b0;
        mode             = MODE_BUS_READ;
        reg_index        = REG_RX_DATA;
        write_data       = '0;
        rx_byte          = '0;
        rx_parity_error  = 1'b0;
        rx_framing_error = 1'b0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fifo_limits();
        test_back_to_back();
        test_random_traffic();

        // let the last results come back and catch any stray strobe
        idle_gap(1);
        repeat (4)
            @(posedge clk);
        if (pending_resp.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_resp.size());
            err_count++;
        end

        $display("Sent %0d words and checked %0d results in %0d cycles.",
                 words_sent, results_checked, cycle_count);
        $display("Saw %0d dropped TX writes, %0d RX overruns, %0d results with irq set.",
                 tx_drops, rx_overruns, irq_high_results);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
